FILE: hw/rtl/base64_codec_unit_macros.svh
// ---------------------------------------------------------------------------
// base64 codec unit assertion macros
// shared assertion forms for the codec's port checker
// ---------------------------------------------------------------------------
`ifndef BASE64_CODEC_UNIT_MACROS_SVH
`define BASE64_CODEC_UNIT_MACROS_SVH

// property checked while out of reset
`define B64C_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define B64C_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/b64c_pkg.sv
// ---------------------------------------------------------------------------
// b64c_pkg
// types, character codes and alphabet functions of the base64 codec
// ---------------------------------------------------------------------------
`default_nettype none

package b64c_pkg;

  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5a;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7a;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_PAD   = 8'h3d;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // one unit of work handed from the front to the back
  typedef struct packed {
    logic        mode;      // encode or decode
    logic [23:0] data;      // three bytes (encode input or decoded output)
    logic [1:0]  last_idx;  // index of the last result of this job
    logic [2:0]  nchar;     // encode: characters before padding
    logic        msg_end;   // job closes the message
  } job_t;

  // {invalid, value}
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c >= CHAR_UC_A && c <= CHAR_UC_Z) r = {1'b0, 6'(c - CHAR_UC_A)};
    else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) r = {1'b0, 6'(c - CHAR_LC_A + 8'd26)};
    else if (c >= CHAR_ZERO && c <= CHAR_NINE) r = {1'b0, 6'(c - CHAR_ZERO + 8'd52)};
    else if (c == CHAR_PLUS) r = 7'd62;
    else if (c == CHAR_SLASH) r = 7'd63;
    return r;
  endfunction

  function automatic logic [7:0] char_of(input logic [5:0] s);
    logic [7:0] r;
    r = CHAR_SLASH;
    if (s < 6'd26) r = CHAR_UC_A + {2'b00, s};
    else if (s < 6'd52) r = CHAR_LC_A + {2'b00, s} - 8'd26;
    else if (s < 6'd62) r = CHAR_ZERO + {2'b00, s} - 8'd52;
    else if (s == 6'd62) r = CHAR_PLUS;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/b64c_front.sv
// ---------------------------------------------------------------------------
// b64c_front
// takes items, keeps group state and forms jobs for the back
// ---------------------------------------------------------------------------
`default_nettype none

module b64c_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic            cfg_mode,
  input  wire logic            accept,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_message_end,
  output b64c_pkg::job_t       job,
  output logic                 job_valid
);

  logic       mode_r, mode_nxt;
  logic [7:0] buf_r [3];
  logic [7:0] buf_nxt [3];
  logic [1:0] count_r, count_nxt;
  logic       stopped_r, stopped_nxt;

  logic [1:0] ce;
  logic [2:0] cn;
  logic [6:0] sx;
  logic [1:0] dc;

  always_comb begin
    mode_nxt    = mode_r;
    buf_nxt     = buf_r;
    count_nxt   = count_r;
    stopped_nxt = stopped_r;
    job         = '0;
    job_valid   = 1'b0;
    ce          = '0;
    cn          = '0;
    dc          = count_r;
    sx          = b64c_pkg::sextet_of(in_byte);
    if (cfg_we) begin
      mode_nxt    = cfg_mode;
      buf_nxt     = '{default: 8'h00};
      count_nxt   = '0;
      stopped_nxt = 1'b0;
    end else if (accept) begin
      job.mode    = mode_r;
      job.msg_end = in_message_end;
      if (mode_r == b64c_pkg::MODE_ENCODE) begin
        ce = (count_r > 2'd2) ? 2'd0 : count_r;
        case (ce)
          2'd0:    buf_nxt[0] = in_byte;
          2'd1:    buf_nxt[1] = in_byte;
          default: buf_nxt[2] = in_byte;
        endcase
        cn = {1'b0, ce} + 3'd1;
        job.last_idx = 2'd3;
        if (cn == 3'd3) begin
          job.data  = {buf_r[0], buf_r[1], in_byte};
          job.nchar = 3'd4;
          job_valid = 1'b1;
          count_nxt = '0;
        end else begin
          count_nxt = cn[1:0];
          if (in_message_end) begin
            job.data  = {buf_nxt[0], (cn == 3'd2) ? buf_nxt[1] : 8'h00, 8'h00};
            job.nchar = cn + 3'd1;
            job_valid = 1'b1;
          end
        end
      end else begin
        if (!stopped_r) begin
          if (sx[6]) begin
            stopped_nxt = 1'b1;
          end else if (count_r == 2'd3) begin
            job.data     = {buf_r[0][5:0], buf_r[1][5:0], buf_r[2][5:0], sx[5:0]};
            job.last_idx = 2'd2;
            job_valid    = 1'b1;
            dc           = '0;
          end else begin
            case (count_r)
              2'd0:    buf_nxt[0] = {2'b00, sx[5:0]};
              2'd1:    buf_nxt[1] = {2'b00, sx[5:0]};
              default: buf_nxt[2] = {2'b00, sx[5:0]};
            endcase
            dc = count_r + 2'd1;
          end
        end
        count_nxt = dc;
        // flush of a partial group at message end
        if (in_message_end && dc >= 2'd2) begin
          job.data     = {buf_nxt[0][5:0], buf_nxt[1][5:0],
                          (dc == 2'd3) ? buf_nxt[2][5:0] : 6'h00, 6'h00};
          job.last_idx = dc - 2'd2;
          job_valid    = 1'b1;
        end
      end
      if (in_message_end) begin
        buf_nxt     = '{default: 8'h00};
        count_nxt   = '0;
        stopped_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= b64c_pkg::MODE_ENCODE;
      buf_r     <= '{default: 8'h00};
      count_r   <= '0;
      stopped_r <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      buf_r     <= buf_nxt;
      count_r   <= count_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/b64c_queue.sv
// ---------------------------------------------------------------------------
// b64c_queue
// small job queue between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module b64c_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire b64c_pkg::job_t wr_job,
  input  wire logic           rd_en,
  output b64c_pkg::job_t      rd_job,
  output logic                q_empty,
  output logic                q_full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64c_pkg::job_t entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign rd_job  = entry_r[rd_ptr_r];
  assign q_empty = (count_r == '0);
  assign q_full  = (count_r == CW'(DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (rd_en) rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (wr_en && !rd_en) count_nxt = count_r + 1'b1;
    else if (rd_en && !wr_en) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) entry_r[wr_ptr_r] <= wr_job;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/b64c_back.sv
// ---------------------------------------------------------------------------
// b64c_back
// steps a job one result per cycle into the output register while it is free or popped
// ---------------------------------------------------------------------------
`default_nettype none

module b64c_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire b64c_pkg::job_t  head,
  input  wire logic            head_valid,
  output logic                 head_done,
  input  wire logic            pop,
  output logic                 empty,
  output logic [7:0]           out_byte,
  output logic                 out_last_of_run,
  output logic                 out_final_result
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       final_r, final_nxt;

  logic       take;
  logic       load;
  logic       is_last;
  logic [5:0] sext;
  logic [7:0] dbyte;

  assign take    = pop && valid_r;
  assign load    = head_valid && (!valid_r || take);
  assign is_last = (idx_r == head.last_idx);
  assign head_done = load && is_last;

  always_comb begin
    case (idx_r)
      2'd0:    sext = head.data[23:18];
      2'd1:    sext = head.data[17:12];
      2'd2:    sext = head.data[11:6];
      default: sext = head.data[5:0];
    endcase
    case (idx_r)
      2'd0:    dbyte = head.data[23:16];
      2'd1:    dbyte = head.data[15:8];
      default: dbyte = head.data[7:0];
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    final_nxt = final_r;
    if (take) valid_nxt = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = is_last ? 2'd0 : idx_r + 2'd1;
      last_nxt  = is_last;
      final_nxt = is_last && head.msg_end;
      if (head.mode == b64c_pkg::MODE_ENCODE) begin
        byte_nxt = ({1'b0, idx_r} < head.nchar) ? b64c_pkg::char_of(sext)
                                                : b64c_pkg::CHAR_PAD;
      end else begin
        byte_nxt = dbyte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    final_r <= final_nxt;
  end

  assign empty            = !valid_r;
  assign out_byte         = byte_r;
  assign out_last_of_run  = last_r;
  assign out_final_result = final_r;

endmodule

`default_nettype wire

FILE: hw/rtl/base64_codec_unit.sv
// ---------------------------------------------------------------------------
// base64_codec_unit
// streaming base64 encoder / decoder with queue-style channels
// ---------------------------------------------------------------------------
// usage
//   cfg_we / cfg_mode: mode select (0 encode, 1 decode); a write also clears
//   the group state, so write it only while the block is idle
//   input side: drive in_byte / in_message_end with push; an item is taken
//   at a clock edge with push high and full low
//   result side: out_byte, out_last_of_run and out_final_result are valid
//   while empty is low; the item is taken at an edge with pop high
//   encode: three bytes give four characters; message end flushes a partial
//   group as two or three characters plus '=' padding
//   decode: four characters give three bytes; '=' or a foreign character
//   stops decoding until message end
//   timing: an item is taken every cycle while the job queue has room; the
//   first result of an item passes the job queue, then the output register
//   results leave one per cycle while pop is high, so the back unit's output
//   register sets the rate: an encode group gives four results per three items
//   a stalled receiver holds the output register; the queue then fills and
//   raises full after QUEUE_DEPTH jobs
//   reset (rst_n low, synchronous) selects encode, clears group state,
//   empties the queue and the output register
// ---------------------------------------------------------------------------
`default_nettype none

module base64_codec_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic       cfg_mode,
  // input channel
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_message_end,
  // result channel
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run,
  output logic            out_final_result
);

  b64c_pkg::job_t new_job;
  b64c_pkg::job_t head_job;
  logic           new_job_valid;
  logic           in_take;
  logic           q_empty;
  logic           head_done;

  // an item is taken whenever the queue has room for its job
  assign in_take = push && !full;

  // front: group collection, classification, job forming
  b64c_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_mode       (cfg_mode),
    .accept         (in_take),
    .in_byte        (in_byte),
    .in_message_end (in_message_end),
    .job            (new_job),
    .job_valid      (new_job_valid)
  );

  // decoupling queue; items that make no result write nothing
  b64c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_take && new_job_valid),
    .wr_job  (new_job),
    .rd_en   (head_done),
    .rd_job  (head_job),
    .q_empty (q_empty),
    .q_full  (full)
  );

  // back: emits each job's results in order through the output register
  b64c_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head_job),
    .head_valid       (!q_empty),
    .head_done        (head_done),
    .pop              (pop),
    .empty            (empty),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run),
    .out_final_result (out_final_result)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/b64c_checker.sv
// ---------------------------------------------------------------------------
// b64c_checker
// port-level checks of the base64 codec unit
// ---------------------------------------------------------------------------
`default_nettype none

`include "base64_codec_unit_macros.svh"

module b64c_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic       out_last_of_run,
  input wire logic       out_final_result
);

  `B64C_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> empty && !full, "not empty after reset")

  `B64C_ASSERT(a_final_is_last, !empty && out_final_result |-> out_last_of_run, "final not last")

  `B64C_ASSERT(a_stall_holds, !empty && !pop |=> !empty && $stable(out_byte), "result dropped")

  `B64C_ASSERT(a_full_needs_result, full |-> !empty, "full with no result waiting")

endmodule

bind base64_codec_unit b64c_checker u_b64c_checker (.*);

`default_nettype wire
